### rtl/ast_pkg.sv
// ============================================================================
// Angle slew turner package
// Shared widths, command codes and the divider control types.
// ============================================================================
package ast_pkg;

    localparam int CMD_W   = 3;
    localparam int TIME_W  = 32;
    localparam int TURN_W  = 32;
    localparam int ANGLE_W = 16;
    localparam int RATE_W  = 16;
    localparam int PROD_W  = TIME_W + RATE_W;
    localparam int DIV_STEPS = TURN_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [CMD_W-1:0] CMD_QUERY    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TURN_BY  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TURN_TO  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET_RATE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESET    = 3'd4;

    localparam logic [TIME_W-1:0] TIME_SAT = {TIME_W{1'b1}};

    typedef struct packed {
        logic              start;
        logic [TURN_W-1:0] dividend;
        logic [RATE_W-1:0] divisor;
    } t_div_ctl;

    typedef struct packed {
        logic              done;
        logic [TURN_W-1:0] quotient;
    } t_div_stat;

endpackage

### rtl/ast_cmd_if.sv
// ============================================================================
// Command channel
// Valid/ready channel carrying one command item.
// ============================================================================
interface ast_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [ast_pkg::CMD_W-1:0]           cmd;
    logic [ast_pkg::TIME_W-1:0]          time_req;
    logic signed [ast_pkg::TURN_W-1:0]   turn_amount;
    logic [ast_pkg::ANGLE_W-1:0]         target_angle;
    logic [ast_pkg::RATE_W-1:0]          new_rate;
    logic [ast_pkg::ANGLE_W-1:0]         new_start_angle;

    modport source (
        output valid, cmd, time_req, turn_amount, target_angle, new_rate, new_start_angle,
        input  ready
    );
    modport sink (
        input  valid, cmd, time_req, turn_amount, target_angle, new_rate, new_start_angle,
        output ready
    );
endinterface

### rtl/ast_res_if.sv
// ============================================================================
// Result channel
// Valid/ready channel carrying one result item.
// ============================================================================
interface ast_res_if;
    logic                                valid;
    logic                                ready;
    logic [ast_pkg::ANGLE_W-1:0]         current_angle;
    logic signed [ast_pkg::TURN_W-1:0]   remaining_turn;
    logic [ast_pkg::TIME_W-1:0]          turn_time;

    modport source (
        output valid, current_angle, remaining_turn, turn_time,
        input  ready
    );
    modport sink (
        input  valid, current_angle, remaining_turn, turn_time,
        output ready
    );
endinterface

### rtl/ast_div.sv
// ============================================================================
// Angle slew turner divider
// Radix-2 restoring divider, one quotient bit per cycle.
// ============================================================================
module ast_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ast_pkg::t_div_ctl  i_ctl,
    output ast_pkg::t_div_stat o_stat
);

    logic                               r_run;
    logic                               r_done;
    logic [ast_pkg::DIV_CNT_W-1:0]      r_cnt;
    logic [ast_pkg::TURN_W-1:0]         r_work;
    logic [ast_pkg::RATE_W-1:0]         r_part;
    logic [ast_pkg::RATE_W-1:0]         r_div;

    logic [ast_pkg::RATE_W:0]           w_shift;
    logic [ast_pkg::RATE_W:0]           w_diff;
    logic                               w_ge;

    // shift in the next dividend bit and trial-subtract
    assign w_shift = {r_part, r_work[ast_pkg::TURN_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_div});
    assign w_diff  = w_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_run  <= 1'b1;
                r_cnt  <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ast_pkg::DIV_CNT_W'(ast_pkg::DIV_STEPS - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_work <= i_ctl.dividend;
            r_part <= '0;
            r_div  <= i_ctl.divisor;
        end else if (r_run) begin
            r_work <= {r_work[ast_pkg::TURN_W-2:0], w_ge};
            r_part <= w_ge ? w_diff[ast_pkg::RATE_W-1:0] : w_shift[ast_pkg::RATE_W-1:0];
        end
    end

    assign o_stat.done     = r_done;
    assign o_stat.quotient = r_work;

endmodule

### rtl/angle_slew_turner_top.sv
// ============================================================================
// Angle slew turner
// Rate-limited binary-angle ramp generator with turn time estimate.
// ============================================================================
// The block tracks an angle (65536 units to a turn) that slews toward its goal
// at a fixed rate in units per tick. Each command item carries a timestamp;
// the block first folds in the turn made since the previous command (rate
// times elapsed ticks, clamped to the remaining turn, nothing if the elapsed
// time is not positive), then applies the command: query, turn by, turn to by
// the shortest route (an exact half turn goes negative), set rate, or reset.
// One result item comes back per command. The command port is busy while an
// item is worked on: every command passes through the multiply, fold and
// command states, and turn by and turn to then run the shared radix-2 divider
// computing |remaining turn| / rate, one quotient bit a cycle (with a zero
// rate the time saturates and the divider is skipped). A finished result sits
// in an output register, so the next item may be accepted while it waits to
// be taken.
// ============================================================================
module angle_slew_turner_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ast_cmd_if.sink       i_cmd,
    ast_res_if.source     o_res
);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_FOLD = 3'd2;
    localparam logic [2:0] S_CMD  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]                          r_state;

    // latched command item
    logic [ast_pkg::CMD_W-1:0]           r_cmd;
    logic [ast_pkg::TIME_W-1:0]          r_time;
    logic [ast_pkg::TURN_W-1:0]          r_amount;
    logic [ast_pkg::ANGLE_W-1:0]         r_target;
    logic [ast_pkg::RATE_W-1:0]          r_new_rate;
    logic [ast_pkg::ANGLE_W-1:0]         r_new_start;

    // slew state
    logic [ast_pkg::TIME_W-1:0]          r_start_time;
    logic [ast_pkg::ANGLE_W-1:0]         r_base;
    logic [ast_pkg::TURN_W-1:0]          r_rem;
    logic [ast_pkg::RATE_W-1:0]          r_rate;

    // fold-in and result work registers
    logic [ast_pkg::PROD_W-1:0]          r_made;
    logic                                r_fold_en;
    logic [ast_pkg::TIME_W-1:0]          r_ttime;

    // output register
    logic                                r_out_valid;
    logic [ast_pkg::ANGLE_W-1:0]         r_out_angle;
    logic [ast_pkg::TURN_W-1:0]          r_out_rem;
    logic [ast_pkg::TIME_W-1:0]          r_out_ttime;

    logic                                w_accept;
    logic                                w_out_free;
    logic                                w_is_turn;
    logic [ast_pkg::TIME_W-1:0]          w_elapsed;
    logic [ast_pkg::TURN_W-1:0]          w_rem_mag;
    logic [ast_pkg::TURN_W-1:0]          w_made_clip;
    logic [ast_pkg::TURN_W-1:0]          w_delta;
    logic [ast_pkg::ANGLE_W-1:0]         n_base;
    logic [ast_pkg::TURN_W-1:0]          n_rem;
    logic [ast_pkg::ANGLE_W-1:0]         w_diff;
    logic [ast_pkg::TURN_W-1:0]          n_cmd_rem;
    logic [ast_pkg::TURN_W-1:0]          w_cmd_mag;

    ast_pkg::t_div_ctl                   w_div_ctl;
    ast_pkg::t_div_stat                  w_div_stat;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_out_free  = !r_out_valid || o_res.ready;

    // elapsed ticks since the last command, wrapping
    assign w_elapsed = r_time - r_start_time;

    // clamp the turn made to the remaining magnitude and give it its sign
    assign w_rem_mag   = r_rem[ast_pkg::TURN_W-1] ? (~r_rem + 1'b1) : r_rem;
    assign w_made_clip = (r_made > {{(ast_pkg::PROD_W-ast_pkg::TURN_W){1'b0}}, w_rem_mag})
                         ? w_rem_mag : r_made[ast_pkg::TURN_W-1:0];
    assign w_delta     = r_rem[ast_pkg::TURN_W-1] ? (~w_made_clip + 1'b1) : w_made_clip;
    assign n_base      = r_base + w_delta[ast_pkg::ANGLE_W-1:0];
    assign n_rem       = r_rem - w_delta;

    // new remaining turn for turn commands; shortest route wraps as signed 16 bits
    assign w_is_turn = (r_cmd == ast_pkg::CMD_TURN_BY) || (r_cmd == ast_pkg::CMD_TURN_TO);
    assign w_diff    = r_target - r_base;
    assign n_cmd_rem = (r_cmd == ast_pkg::CMD_TURN_BY) ? r_amount
                     : {{(ast_pkg::TURN_W-ast_pkg::ANGLE_W){w_diff[ast_pkg::ANGLE_W-1]}}, w_diff};
    assign w_cmd_mag = n_cmd_rem[ast_pkg::TURN_W-1] ? (~n_cmd_rem + 1'b1) : n_cmd_rem;

    assign w_div_ctl.start    = (r_state == S_CMD) && w_is_turn && (r_rate != '0);
    assign w_div_ctl.dividend = w_cmd_mag;
    assign w_div_ctl.divisor  = r_rate;

    ast_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_div_ctl),
        .o_stat (w_div_stat)
    );

    // sequencer and slew state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_start_time <= '0;
            r_base       <= '0;
            r_rem        <= '0;
            r_rate       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_FOLD;
                end
                S_FOLD: begin
                    // fold in the turn made, or load the reset values
                    r_start_time <= r_time;
                    if (r_cmd == ast_pkg::CMD_RESET) begin
                        r_base <= r_new_start;
                        r_rem  <= '0;
                    end else if (r_fold_en) begin
                        r_base <= n_base;
                        r_rem  <= n_rem;
                    end
                    r_state <= S_CMD;
                end
                S_CMD: begin
                    if (w_is_turn) begin
                        r_rem <= n_cmd_rem;
                    end
                    if (r_cmd == ast_pkg::CMD_SET_RATE) begin
                        r_rate <= r_new_rate;
                    end
                    r_state <= w_div_ctl.start ? S_DIV : S_OUT;
                end
                S_DIV: begin
                    if (w_div_stat.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd       <= i_cmd.cmd;
            r_time      <= i_cmd.time_req;
            r_amount    <= i_cmd.turn_amount;
            r_target    <= i_cmd.target_angle;
            r_new_rate  <= i_cmd.new_rate;
            r_new_start <= i_cmd.new_start_angle;
        end
        if (r_state == S_MUL) begin
            r_made    <= {{ast_pkg::TIME_W{1'b0}}, r_rate}
                       * {{ast_pkg::RATE_W{1'b0}}, w_elapsed};
            r_fold_en <= (w_elapsed != '0) && !w_elapsed[ast_pkg::TIME_W-1]
                         && (r_rem != '0) && (r_cmd != ast_pkg::CMD_RESET);
        end
        if (r_state == S_CMD) begin
            // zero rate saturates the time; other commands report zero
            r_ttime <= (w_is_turn && (r_rate == '0)) ? ast_pkg::TIME_SAT : '0;
        end
        if ((r_state == S_DIV) && w_div_stat.done) begin
            r_ttime <= w_div_stat.quotient;
        end
        if ((r_state == S_OUT) && w_out_free) begin
            r_out_angle <= r_base;
            r_out_rem   <= r_rem;
            r_out_ttime <= r_ttime;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.current_angle  = r_out_angle;
    assign o_res.remaining_turn = r_out_rem;
    assign o_res.turn_time      = r_out_ttime;

endmodule
